@@ sv/oal_pkg.sv @@
// Shared types and constants for the ordered array list.
// Depends on nothing; oal_ctrl, oal_dp, the top and the testbench import it.
package oal_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 7;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_ERASE  = 2'd2,
      OP_GET    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_BAD  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CHECK,
      S_READ,
      S_WRITE,
      S_GET,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;      // take the request fields
      logic rd_en;      // read the store at the source address
      logic wr_shift;   // write the moved entry at the cursor
      logic wr_final;   // write the new value at the cursor
      logic step;       // advance the cursor one entry
      logic cnt_inc;
      logic cnt_dec;
      logic load_rsp;   // load the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   ok;       // request passed its index and space checks
      logic   at_end;   // cursor reached the end of the move
      logic   rsp_free; // output register can take a result
   } sts_type;

endpackage

@@ sv/oal_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module oal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/oal_ctrl.sv @@
// Sequencer for the ordered array list: decode, entry moves, result hand-off.
// Depends on oal_pkg.
module oal_ctrl
   import oal_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (!sts.ok) begin
               state_in = S_DONE;
            end else if (sts.op == OP_GET) begin
               state_in = S_GET;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.at_end) begin
               if (sts.op == OP_ERASE) begin
                  cmd.cnt_dec = 1'b1;
               end else begin
                  cmd.wr_final = 1'b1;
                  cmd.cnt_inc  = 1'b1;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr_shift = 1'b1;
            cmd.step     = 1'b1;
            state_in     = S_CHECK;
         end
         S_GET: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ sv/oal_dp.sv @@
// Datapath for the ordered array list: count, cursor, element store, output register.
// Depends on oal_pkg and oal_ram.
module oal_dp
   import oal_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  logic [1:0]                 req_type,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_value_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_read_value,
   output logic [1:0]                 rsp_status,
   output logic [COUNT_W-1:0]         rsp_entry_count,
   output logic                       rsp_is_empty
);

   op_type              op_ff;
   status_type          stat_ff, stat_in;
   logic [IDX_W-1:0]    pos_ff;
   logic [IDX_W-1:0]    cur_ff;
   logic [DATA_W-1:0]   val_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_value_ff;
   logic [1:0]          rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_empty_ff;

   op_type              req_op;
   logic [CMP_W-1:0]    pos_cmp;
   logic [CMP_W-1:0]    cnt_cmp;
   logic                full;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic [DATA_W-1:0]   rd_data;
   logic [DATA_W-1:0]   rsp_value_in;

   assign req_op  = op_type'(req_type);
   assign pos_cmp = CMP_W'(req_position);
   assign cnt_cmp = CMP_W'(cnt_ff);
   assign full    = (cnt_ff == CNT_W'(CAPACITY));

   // index check first, then space
   always_comb begin
      stat_in = ST_DONE;
      unique case (req_op)
         OP_APPEND: if (full) stat_in = ST_FULL;
         OP_INSERT: begin
            priority if (pos_cmp > cnt_cmp) begin
               stat_in = ST_BAD;
            end else if (full) begin
               stat_in = ST_FULL;
            end
         end
         OP_ERASE,
         OP_GET:    if (pos_cmp >= cnt_cmp) stat_in = ST_BAD;
         default:   stat_in = ST_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_op;
         stat_ff <= stat_in;
         val_ff  <= req_value_in;
         // append writes at the tail, same path as insert there
         if (req_op == OP_APPEND) begin
            pos_ff <= IDX_W'(cnt_ff);
         end else begin
            pos_ff <= IDX_W'(req_position);
         end
         if (req_op == OP_APPEND || req_op == OP_INSERT) begin
            cur_ff <= IDX_W'(cnt_ff);
         end else begin
            cur_ff <= IDX_W'(req_position);
         end
      end else if (cmd.step) begin
         if (op_ff == OP_ERASE) begin
            cur_ff <= cur_ff + IDX_W'(1);
         end else begin
            cur_ff <= cur_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   // insert pulls from below the cursor, erase from above
   always_comb begin
      unique case (op_ff)
         OP_ERASE:  rd_addr = cur_ff + IDX_W'(1);
         OP_GET:    rd_addr = cur_ff;
         default:   rd_addr = cur_ff - IDX_W'(1);
      endcase
   end

   assign wr_addr = cur_ff;
   assign wr_data = cmd.wr_final ? val_ff : rd_data;

   oal_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_shift | cmd.wr_final),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sts.op       = op_ff;
      sts.ok       = (stat_ff == ST_DONE);
      sts.rsp_free = !rsp_valid_ff || rsp_ready;
      if (op_ff == OP_ERASE) begin
         sts.at_end = ((CNT_W'(cur_ff) + CNT_W'(1)) == cnt_ff);
      end else begin
         sts.at_end = (cur_ff == pos_ff);
      end
   end

   always_comb begin
      rsp_value_in = '0;
      if (op_ff == OP_GET) begin
         rsp_value_in = (stat_ff == ST_DONE) ? rd_data : '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= stat_ff;
         rsp_count_ff  <= COUNT_W'(cnt_ff);
         rsp_empty_ff  <= (cnt_ff == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = $signed(rsp_value_ff);
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule

@@ sv/ordered_array_list.sv @@
// Top level of the ordered array list: sequencer plus datapath.
// Depends on oal_pkg, oal_ctrl, oal_dp (and through it oal_ram).
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | req_type, req_position, req_value_in
//   rsp_    | out       | rsp_valid / rsp_ready | rsp_read_value, rsp_status,
//           |           |                       | rsp_entry_count, rsp_is_empty
//
// One request at a time. Get runs accept, decode, RAM read, result load; append runs
// accept, decode, a check that writes the value, result load; a refused request runs
// accept, decode, result load. Insert moves (count - position) entries, erase (count -
// position - 1), each through check, read and write, as the RAM read data is registered.
// Reset clears the count and the handshake state; the store needs no clearing,
// since only entries below the count are ever read. No request is taken in reset.
// The output register parts the channels: the next request is taken while a
// result waits; a stalled result holds the sequencer only at its hand-off.
module ordered_array_list
   import oal_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_value_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DATA_W-1:0]  rsp_read_value,
   output logic [1:0]                rsp_status,
   output logic [COUNT_W-1:0]        rsp_entry_count,
   output logic                      rsp_is_empty
);

   // commands down, status up
   cmd_type cmd;
   sts_type sts;

   // sequencer: decode, move loop, result hand-off
   oal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: count, cursor, element RAM, output register
   oal_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_value_in    (req_value_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

@@ dv/tb_top.sv @@
// Testbench top for ordered_array_list: drives requests, tracks a shadow list,
// and compares every result field by field. Depends on oal_pkg and the RTL top.
module tb_top;
   import oal_pkg::*;

   localparam int N_ITEMS      = 1800;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int HOLD_CYCLES  = 300;
   // worst move is an insert at the head of a list one entry short of full
   localparam int DRAIN_CYCLES = 3 * CAPACITY + 20;

   typedef enum int {
      LEAN_GROW,
      LEAN_SHRINK,
      LEAN_EVEN
   } lean_type;

   typedef struct {
      logic signed [DATA_W-1:0] read_value;
      status_type               status;
      logic [COUNT_W-1:0]       entry_count;
      logic                     is_empty;
   } list_result_type;

   // Shadow of the list contents plus the results still owed by the block.
   class list_shadow_type;
      logic signed [DATA_W-1:0] slots [CAPACITY];
      int unsigned              used;
      list_result_type          pending_results [$];
      int unsigned              errors;
      int unsigned              checked;
      int unsigned              op_seen [4];
      int unsigned              bad_seen;
      int unsigned              full_seen;

      function void note_request(op_type op, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] val);
         list_result_type want;
         int unsigned     p;
         p = pos;
         want.read_value = '0;
         want.status     = ST_DONE;
         op_seen[op]++;
         case (op)
            OP_APPEND: begin
               if (used >= CAPACITY) begin
                  want.status = ST_FULL;
               end else begin
                  slots[used] = val;
                  used++;
               end
            end
            OP_INSERT: begin
               // index check wins over the full check
               if (p > used) begin
                  want.status = ST_BAD;
               end else if (used >= CAPACITY) begin
                  want.status = ST_FULL;
               end else begin
                  for (int i = used; i > p; i--) slots[i] = slots[i-1];
                  slots[p] = val;
                  used++;
               end
            end
            OP_ERASE: begin
               if (p >= used) begin
                  want.status = ST_BAD;
               end else begin
                  for (int i = p; i + 1 < used; i++) slots[i] = slots[i+1];
                  used--;
               end
            end
            default: begin
               if (p >= used) begin
                  want.status     = ST_BAD;
                  want.read_value = -1;
               end else begin
                  want.read_value = slots[p];
               end
            end
         endcase
         if (want.status == ST_BAD) bad_seen++;
         if (want.status == ST_FULL) full_seen++;
         want.entry_count = COUNT_W'(used);
         want.is_empty    = (used == 0);
         pending_results = {pending_results, want};
      endfunction

      function void check_result(logic signed [DATA_W-1:0] rd, logic [1:0] st,
                                 logic [COUNT_W-1:0] cnt, logic empty);
         list_result_type want;
         if (pending_results.size() == 0) begin
            $error("result with no request waiting: read_value %0d status %0d", rd, st);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (rd !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, rd);
            errors++;
         end
         if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            errors++;
         end
         if (cnt !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, cnt);
            errors++;
         end
         if (empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, empty);
            errors++;
         end
      endfunction

      function int unsigned owed();
         return pending_results.size();
      endfunction
   endclass

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_type     = OP_APPEND;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value_in = '0;
   logic                     rsp_valid;
   logic                     rsp_ready    = 1'b0;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [1:0]               rsp_status;
   logic [COUNT_W-1:0]       rsp_entry_count;
   logic                     rsp_is_empty;

   list_shadow_type list_sb;
   int unsigned cycle_count   = 0;
   int unsigned req_sent      = 0;
   // idling knobs, percent of cycles; written by the stimulus only
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   // long receiver hold-offs: asked by the stimulus, served by the receiver
   int unsigned hold_asked    = 0;
   int unsigned hold_done     = 0;

   ordered_array_list dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_value_in    (req_value_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Count cycles and drop the run if it hangs.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Check each result the moment it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         list_sb.check_result(rsp_read_value, rsp_status, rsp_entry_count, rsp_is_empty);
   end

   // Receiver: stall at the current rate, or hold off for a long stretch on demand.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_asked != hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_done = hold_asked;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offer one request, idling first at the current rate; hold it until taken.
   task automatic send_request(op_type op, int unsigned pos, logic signed [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= op;
      req_position <= pos[POS_W-1:0];
      req_value_in <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      list_sb.note_request(op, pos[POS_W-1:0], val);
      req_sent++;
   endtask

   // Drop valid and wait until every owed result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (list_sb.owed() != 0);
   endtask

   task automatic set_idling(int unsigned mode);
      case (mode)
         0:       begin send_idle_pct = 0;  stall_pct = 0;  end
         1:       begin send_idle_pct = 85; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 85; end
         default: begin send_idle_pct = 9;  stall_pct = 9;  end
      endcase
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return -1;
         3:       return 0;
         default: return $urandom;
      endcase
   endfunction

   // Mostly legal positions; a few anywhere in the 7-bit range.
   function automatic int unsigned pick_position(op_type op);
      if (op == OP_APPEND || $urandom_range(99) < 8) return $urandom_range(127);
      if (op == OP_INSERT) return $urandom_range(list_sb.used);
      if (list_sb.used == 0) return 0;
      return $urandom_range(list_sb.used - 1);
   endfunction

   function automatic op_type pick_op(lean_type lean);
      int unsigned r;
      r = $urandom_range(99);
      case (lean)
         LEAN_GROW:
            return (r < 40) ? OP_APPEND : (r < 75) ? OP_INSERT : (r < 85) ? OP_ERASE : OP_GET;
         LEAN_SHRINK:
            return (r < 10) ? OP_APPEND : (r < 20) ? OP_INSERT : (r < 80) ? OP_ERASE : OP_GET;
         default:
            return op_type'(r / 25);
      endcase
   endfunction

   task automatic send_random(lean_type lean);
      op_type op;
      op = pick_op(lean);
      send_request(op, pick_position(op), pick_value());
   endtask

   // Fill the list with appends and inserts, then poke at the full list.
   task automatic fill_and_probe();
      op_type op;
      while (list_sb.used < CAPACITY) begin
         op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
         send_request(op, pick_position(op), pick_value());
      end
      send_request(OP_APPEND, 0, pick_value());
      send_request(OP_INSERT, $urandom_range(CAPACITY), pick_value());
      send_request(OP_INSERT, CAPACITY + 1, pick_value());
      send_request(OP_GET, CAPACITY - 1, pick_value());
      send_request(OP_GET, CAPACITY, pick_value());
      send_request(OP_ERASE, $urandom_range(CAPACITY - 1), pick_value());
   endtask

   initial begin : stimulus
      int unsigned ep;
      ep      = 0;
      list_sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list refusals, extreme values and positions, head/tail edits.
      set_idling(0);
      send_request(OP_GET,    0,   32'sh1234_5678);
      send_request(OP_ERASE,  0,   0);
      send_request(OP_INSERT, 1,   5);
      send_request(OP_INSERT, 127, 6);
      send_request(OP_APPEND, 0,   32'sh7fff_ffff);
      send_request(OP_APPEND, 127, 32'sh8000_0000);
      send_request(OP_INSERT, 0,   -1);
      send_request(OP_INSERT, 3,   0);
      send_request(OP_INSERT, 2,   32'sh5555_5555);
      send_request(OP_GET,    0,   0);
      send_request(OP_GET,    4,   0);
      send_request(OP_GET,    5,   0);
      send_request(OP_GET,    127, -1);
      send_request(OP_GET,    64,  0);
      send_request(OP_ERASE,  5,   0);
      send_request(OP_ERASE,  4,   0);
      send_request(OP_ERASE,  0,   0);
      send_request(OP_ERASE,  1,   0);
      send_request(OP_APPEND, 0,   32'shaaaa_aaaa);
      send_request(OP_GET,    1,   0);
      send_request(OP_ERASE,  0,   0);
      send_request(OP_ERASE,  0,   0);
      send_request(OP_ERASE,  0,   0);
      send_request(OP_GET,    0,   0);
      wait_for_results();

      // Random episodes: rotate the idling mix, fill to capacity now and then,
      // drain toward empty, and stall the receiver hard while requests pile up.
      while (req_sent < N_ITEMS) begin
         set_idling(ep % 4);
         if (ep % 5 == 0) begin
            fill_and_probe();
         end else if (ep % 5 == 3) begin
            while (list_sb.used > 0) send_random(LEAN_SHRINK);
            repeat (4) send_random(LEAN_EVEN);
         end else begin
            repeat ($urandom_range(40, 120)) send_random(lean_type'(ep % 3));
         end
         if (ep == 2 || ep == 7) begin
            set_idling(0);
            hold_asked++;
            repeat (24) send_random(LEAN_GROW);
         end
         if (ep % 3 == 1) wait_for_results();
         ep++;
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests (append %0d, insert %0d, erase %0d, get %0d),",
               req_sent, list_sb.op_seen[OP_APPEND], list_sb.op_seen[OP_INSERT],
               list_sb.op_seen[OP_ERASE], list_sb.op_seen[OP_GET]);
      $display("%0d results checked; %0d refused for a bad index, %0d for a full list, %0d cycles.",
               list_sb.checked, list_sb.bad_seen, list_sb.full_seen, cycle_count);
      if (list_sb.errors == 0 && list_sb.owed() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
